// ===== rtl/pinball_board_io_decoder_defines.svh =====
// assertion macros for the pinball board i/o decoder
// used by the top level only; relies on clock and reset in the including scope
`ifndef PINBALL_BOARD_IO_DECODER_DEFINES_SVH
`define PINBALL_BOARD_IO_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PBD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define PBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pbd_pkg.sv =====
// shared types, codes, constants and helper functions of the pinball board i/o decoder
// no dependencies
package pbd_pkg;

   localparam int RAM_DEPTH   = 256;
   localparam int RAM_AW      = $clog2(RAM_DEPTH);
   localparam int SWITCH_COLS = 8;
   localparam int SW_AW       = (SWITCH_COLS > 1) ? $clog2(SWITCH_COLS) : 1;
   localparam int DIGITS      = 8;
   localparam int SEG_W       = 7;

   localparam logic [7:0]  PORT1_RESET = 8'hff;
   localparam logic [15:0] SOL_HI_MASK = 16'hff00;
   localparam logic [15:0] SOL_LO_MASK = 16'h00ff;

   typedef enum logic [2:0] {
      CMD_PORT_RD = 3'd0,
      CMD_PORT_WR = 3'd1,
      CMD_P1_WR   = 3'd2,
      CMD_P2_WR   = 3'd3,
      CMD_P1_RD   = 3'd4,
      CMD_P2_RD   = 3'd5,
      CMD_FRAME   = 3'd6,
      CMD_SW_SET  = 3'd7
   } cmd_type;

   // select nibble codes (high nibble of the port 2 latch)
   localparam logic [3:0] SEL_SWITCH   = 4'd0;
   localparam logic [3:0] SEL_SOL_BANK = 4'd1;
   localparam logic [3:0] SEL_SOL_DATA = 4'd2;
   localparam logic [3:0] SEL_BLANK    = 4'd3;
   localparam logic [3:0] SEL_DIP_A    = 4'd4;
   localparam logic [3:0] SEL_DIP_B    = 4'd5;
   localparam logic [3:0] SEL_DIP_D    = 4'd6;
   localparam logic [3:0] SEL_DIP_C    = 4'd7;
   localparam logic [3:0] SEL_SEG0     = 4'd8;
   localparam logic [3:0] SEL_SEG1     = 4'd9;
   localparam logic [3:0] SEL_SEG2     = 4'd10;
   localparam logic [3:0] SEL_SEG3     = 4'd11;
   localparam logic [3:0] SEL_LAMP     = 4'd12;
   localparam logic [3:0] SEL_STROBE   = 4'd13;
   localparam logic [3:0] SEL_RAM_WR   = 4'd14;

   typedef enum logic [1:0] {
      REG_DIP_A = 2'd0,
      REG_DIP_B = 2'd1,
      REG_DIP_C = 2'd2,
      REG_DIP_D = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] offset;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [7:0]              read_data;
      logic [15:0]             solenoid_drive;
      logic                    strobe_valid;
      logic [2:0]              strobe_column;
      logic [7:0]              lamp_bits;
      logic [DIGITS*SEG_W-1:0] digit_segments;
   } rsp_type;

   typedef logic [RAM_AW-1:0] ram_addr_type;
   typedef ram_addr_type ram_index_table_type [256];

   // 7448-style segment patterns
   localparam logic [SEG_W-1:0] SEG7_TABLE [16] = '{
      7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7c, 7'h07,
      7'h7f, 7'h67, 7'h58, 7'h4c, 7'h62, 7'h69, 7'h78, 7'h00
   };

   // port offset folded into the ram depth, built at elaboration
   function automatic ram_index_table_type build_ram_index_table();
      ram_index_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = RAM_AW'(i % RAM_DEPTH);
      end
      return t;
   endfunction

   localparam ram_index_table_type RAM_INDEX_TABLE = build_ram_index_table();

   function automatic logic [2:0] lowest_bit(input logic [7:0] v);
      logic [2:0] r;
      r = '0;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            r = 3'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] reverse8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[i];
      end
      return r;
   endfunction

endpackage

// ===== rtl/pinball_board_io_decoder.sv =====
// pinball board i/o decoder top level; uses pbd_pkg, pbd_ram and the assertion macro header
// items pass stage 1, then the output register; one item per cycle when not stalled
// the scratch ram read (synchronous, registered) sets the two-stage depth
// reset (synchronous, active high) restores all latches and starts a ram clearing pass
// over all RAM_DEPTH (256) words, during which req_stall stays high; csr writes still land
`include "pinball_board_io_decoder_defines.svh"

module pinball_board_io_decoder (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  pbd_pkg::req_type req_item,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output pbd_pkg::rsp_type rsp_item,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [7:0]      csr_wdata
);

   import pbd_pkg::*;

   // configuration registers
   logic [7:0] dip_a_ff, dip_b_ff, dip_c_ff, dip_d_ff;

   // architectural latches
   logic [7:0]  port1_ff, port1_in;
   logic [7:0]  port2_ff, port2_in;
   logic [7:0]  sol_bank_ff, sol_bank_in;
   logic [15:0] sol_latch_ff, sol_latch_in;
   logic [15:0] sol_pub_ff, sol_pub_in;
   logic        parity_ff, parity_in;
   logic [7:0]  lamp_ff, lamp_in;
   logic [7:0]  blank_ff, blank_in;
   logic [7:0]  seg_ff [4];
   logic [7:0]  seg_in [4];
   logic [7:0]  sw_ff [SWITCH_COLS];
   logic [7:0]  sw_in [SWITCH_COLS];

   // ram clearing pass after reset
   logic         clearing_ff, clearing_in;
   ram_addr_type clear_ptr_ff, clear_ptr_in;

   // stage 1: item decoded, ram read in flight
   logic    s1_valid_ff, s1_valid_in;
   rsp_type s1_rsp_ff, s1_rsp_in;
   logic    s1_use_ram_ff, s1_use_ram_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff, rsp_item_in;

   // handshake
   logic out_ready;
   logic s1_adv;
   logic req_accept;

   // ram port
   logic         ram_we;
   ram_addr_type ram_waddr;
   logic [7:0]   ram_wdata;
   ram_addr_type ram_idx;
   logic [7:0]   ram_rdata;

   // decode helpers
   logic [3:0]              sel;
   logic [2:0]              sw_col;
   logic [7:0]              sw_row;
   logic [7:0]              seg_byte;
   logic [3:0]              seg_nib;
   logic [DIGITS*SEG_W-1:0] segs;

   // ------------------------------------------------------------------
   // handshake: output register frees stage 1, stage 1 frees the input
   // ------------------------------------------------------------------
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv     = s1_valid_ff && out_ready;
   assign req_stall  = clearing_ff || (s1_valid_ff && !out_ready);
   assign req_accept = req_valid && !req_stall;

   assign sel     = port2_ff[7:4];
   assign ram_idx = RAM_INDEX_TABLE[req_item.offset];

   // switch row seen by a port read: column from the active-low port 1 strobe
   assign sw_col = lowest_bit(~port1_ff);
   assign sw_row = (int'(sw_col) < SWITCH_COLS) ? sw_ff[sw_col[SW_AW-1:0]] : 8'h00;

   // display digits: two bcd nibbles per latch, blanked by mask bit
   always_comb begin
      segs     = '0;
      seg_byte = '0;
      seg_nib  = '0;
      for (int k = 0; k < DIGITS; k++) begin
         seg_byte = seg_ff[k/2];
         seg_nib  = (k % 2 == 1) ? seg_byte[7:4] : seg_byte[3:0];
         segs[SEG_W*k +: SEG_W] = blank_ff[k] ? '0 : SEG7_TABLE[seg_nib];
      end
   end

   // ------------------------------------------------------------------
   // item decode: all latch updates happen at the transfer edge, so the
   // next item (accepted at a later transfer) always sees them; the ram is
   // written here too, so a read of the next item sees the new byte
   // ------------------------------------------------------------------
   always_comb begin
      port1_in      = port1_ff;
      port2_in      = port2_ff;
      sol_bank_in   = sol_bank_ff;
      sol_latch_in  = sol_latch_ff;
      sol_pub_in    = sol_pub_ff;
      parity_in     = parity_ff;
      lamp_in       = lamp_ff;
      blank_in      = blank_ff;
      seg_in        = seg_ff;
      sw_in         = sw_ff;
      s1_use_ram_in = 1'b0;
      s1_rsp_in     = '0;
      ram_we        = 1'b0;
      ram_waddr     = ram_idx;
      ram_wdata     = req_item.data;

      unique case (cmd_type'(req_item.cmd))
         CMD_PORT_RD: begin
            unique case (sel)
               SEL_SWITCH: s1_rsp_in.read_data = ~reverse8(sw_row);
               SEL_DIP_A:  s1_rsp_in.read_data = dip_a_ff;
               SEL_DIP_B:  s1_rsp_in.read_data = dip_b_ff;
               SEL_DIP_D:  s1_rsp_in.read_data = dip_d_ff;
               SEL_DIP_C:  s1_rsp_in.read_data = dip_c_ff;
               default:    s1_use_ram_in = 1'b1;
            endcase
         end
         CMD_PORT_WR: begin
            unique case (sel)
               SEL_SWITCH, SEL_RAM_WR: ram_we = 1'b1;
               SEL_SOL_BANK: begin
                  sol_bank_in = req_item.data;
                  if (req_item.data == 8'h00) begin
                     sol_latch_in = '0;
                  end
               end
               SEL_SOL_DATA: begin
                  if (sol_bank_ff != 8'h00) begin
                     parity_in = 1'b0;
                     if (sol_bank_ff[0]) begin
                        sol_latch_in = (sol_latch_in & SOL_HI_MASK) | {8'h00, req_item.data};
                     end
                     if (sol_bank_ff[1]) begin
                        sol_latch_in = (sol_latch_in & SOL_LO_MASK) | {req_item.data, 8'h00};
                     end
                     // nonzero data publishes at once
                     if (req_item.data != 8'h00) begin
                        sol_pub_in = sol_latch_in;
                     end
                  end
               end
               SEL_BLANK: blank_in = ~req_item.data;
               SEL_SEG0:  seg_in[0] = req_item.data;
               SEL_SEG1:  seg_in[1] = req_item.data;
               SEL_SEG2:  seg_in[2] = req_item.data;
               SEL_SEG3:  seg_in[3] = req_item.data;
               SEL_LAMP:  lamp_in = req_item.data;
               SEL_STROBE: begin
                  s1_rsp_in.strobe_valid   = 1'b1;
                  s1_rsp_in.strobe_column  = lowest_bit(req_item.data);
                  s1_rsp_in.lamp_bits      = lamp_ff;
                  s1_rsp_in.digit_segments = segs;
               end
               default: ;
            endcase
         end
         CMD_P1_WR: port1_in = req_item.data;
         CMD_P2_WR: port2_in = req_item.data;
         CMD_P1_RD: s1_rsp_in.read_data = port1_ff;
         CMD_P2_RD: s1_rsp_in.read_data = port2_ff;
         CMD_FRAME: begin
            // publish on every second tick
            parity_in = ~parity_ff;
            if (parity_ff) begin
               sol_pub_in = sol_latch_ff;
            end
         end
         CMD_SW_SET: begin
            if (int'(req_item.offset) < SWITCH_COLS) begin
               sw_in[req_item.offset[SW_AW-1:0]] = req_item.data;
            end
         end
      endcase

      s1_rsp_in.solenoid_drive = sol_pub_in;

      // the clearing pass owns the write port; no transfer happens meanwhile
      if (clearing_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clear_ptr_ff;
         ram_wdata = '0;
      end else if (!req_accept) begin
         ram_we = 1'b0;
      end
   end

   pbd_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_scratch_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (req_accept),
      .raddr (ram_idx),
      .rdata (ram_rdata)
   );

   // ------------------------------------------------------------------
   // pipeline and clearing control
   // ------------------------------------------------------------------
   always_comb begin
      clearing_in  = clearing_ff;
      clear_ptr_in = clear_ptr_ff;
      if (clearing_ff) begin
         clear_ptr_in = clear_ptr_ff + 1'b1;
         if (clear_ptr_ff == RAM_AW'(RAM_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end

      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      // ram data is held by the ram while stage 1 waits
      rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;
      rsp_item_in  = s1_rsp_ff;
      if (s1_use_ram_ff) begin
         rsp_item_in.read_data = ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_ptr_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_ptr_ff <= clear_ptr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_rsp_ff     <= s1_rsp_in;
         s1_use_ram_ff <= s1_use_ram_in;
      end
      if (s1_adv) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // latches, updated on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         port1_ff     <= PORT1_RESET;
         port2_ff     <= '0;
         sol_bank_ff  <= '0;
         sol_latch_ff <= '0;
         sol_pub_ff   <= '0;
         parity_ff    <= 1'b0;
         lamp_ff      <= '0;
         blank_ff     <= '0;
         seg_ff       <= '{default: '0};
         sw_ff        <= '{default: '0};
      end else if (req_accept) begin
         port1_ff     <= port1_in;
         port2_ff     <= port2_in;
         sol_bank_ff  <= sol_bank_in;
         sol_latch_ff <= sol_latch_in;
         sol_pub_ff   <= sol_pub_in;
         parity_ff    <= parity_in;
         lamp_ff      <= lamp_in;
         blank_ff     <= blank_in;
         seg_ff       <= seg_in;
         sw_ff        <= sw_in;
      end
   end

   // dip switch registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dip_a_ff <= '0;
         dip_b_ff <= '0;
         dip_c_ff <= '0;
         dip_d_ff <= '0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_DIP_A: dip_a_ff <= csr_wdata;
            REG_DIP_B: dip_b_ff <= csr_wdata;
            REG_DIP_C: dip_c_ff <= csr_wdata;
            REG_DIP_D: dip_d_ff <= csr_wdata;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `PBD_ASSERT_NEXT(a_accept_fills_s1, req_accept, s1_valid_ff, "transfer did not reach stage 1")
   `PBD_ASSERT_NEXT(a_s1_holds, s1_valid_ff && !out_ready, s1_valid_ff && $stable(s1_rsp_ff), "stage 1 lost a waiting item")
   `PBD_ASSERT_NOW(a_clear_length, $fell(clearing_ff), $past(clear_ptr_ff) == RAM_AW'(RAM_DEPTH - 1), "ram clearing pass ended early")
   `PBD_ASSERT_NEXT(a_s1_to_out, s1_adv, rsp_valid_ff, "stage 1 item not moved to output")

endmodule

// ===== rtl/pbd_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module pbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // read data holds while no read is issued
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
